// ===== rtl/sha256_stream_hash_core_macros.svh =====
// Assertion macros for the SHA-256 stream hash core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SHA256_STREAM_HASH_CORE_MACROS_SVH
`define SHA256_STREAM_HASH_CORE_MACROS_SVH

`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sha256sh_pkg.sv =====
// Shared types and constants for the SHA-256 stream hash core.
// No dependencies; imported by the engine and the top level.
package sha256sh_pkg;

  localparam int unsigned BLK_WORDS   = 16;
  localparam int unsigned CHAIN_WORDS = 8;
  localparam int unsigned BLK_AW      = $clog2(BLK_WORDS);
  localparam int unsigned CHAIN_AW    = $clog2(CHAIN_WORDS);

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [5:0] SEQ_PREFETCH = 6'd7;
  localparam logic [5:0] SEQ_LAST     = 6'd8;
  localparam logic [5:0] ROUND_LAST   = 6'd63;
  localparam logic [5:0] ROUND_MEM_END = 6'd15;
  localparam logic [2:0] WORD_LAST    = 3'd7;

  localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_UPDATE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } fsm_t;

  typedef struct packed {
    logic       v_shift;
    logic       v_round;
    logic       w_shift;
    logic       w_from_mem;
    logic [5:0] rnd;
  } eng_ctrl_t;

endpackage

// ===== rtl/sha256_stream_hash_core.sv =====
// Top level of the SHA-256 stream hash core: byte packing, padding, sequencing.
// Depends on sha256sh_pkg, sha256sh_ram, sha256sh_engine and the macros header.
//
// Usage: the input channel takes one transaction per item: an optional message
// byte (in_has_byte) and an end-of-message flag. Bytes are packed into 32-bit
// words in a 16-word block RAM; the eight chaining words live in an 8-word RAM.
// A byte that does not fill the block leaves the core idle and ready. The 64th
// byte of a block holds the input while the core reads the chaining words,
// runs the rounds through the single round engine, then adds and writes the
// chaining words back. A closing transaction pads one byte per cycle up to
// the block end (two blocks when fewer than nine bytes remain), compresses,
// then sends eight digest words H0 first on the result channel, each read
// from the chaining RAM and held until taken; out_final_word marks the eighth.
// A stalled receiver holds the result register and the whole core until the
// word is taken; no input is accepted while a digest is pending.
// Reset (synchronous, active low) empties the block, clears the bit count
// and marks the chaining RAM as holding the initial hash, so no clearing
// pass is needed and the first transaction may follow at once.
`include "sha256_stream_hash_core_macros.svh"

module sha256_stream_hash_core import sha256sh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  fsm_t        state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bit_total_r, bit_total_nxt;
  logic        fresh_r, fresh_nxt;
  logic        pad_r, pad_nxt;
  logic        sent80_r, sent80_nxt;
  logic        need_extra_r, need_extra_nxt;
  logic        final_r, final_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] word_r, word_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_fin_r, out_fin_nxt;

  logic                byte_en;
  logic [7:0]          byte_val;
  logic                blk_we;
  logic [BLK_AW-1:0]   blk_waddr;
  logic [31:0]         blk_wdata;
  logic [BLK_AW-1:0]   blk_raddr;
  logic [31:0]         blk_rdata;
  logic                chain_we;
  logic [CHAIN_AW-1:0] chain_waddr;
  logic [31:0]         chain_wdata;
  logic [CHAIN_AW-1:0] chain_raddr;
  logic [31:0]         chain_rdata;
  logic [31:0]         chain_sel;
  logic [CHAIN_AW-1:0] cnt_prev;
  logic [5:0]          cnt_ahead;
  logic [7:0]          len_byte;
  logic [31:0]         v_head;
  eng_ctrl_t           eng_ctrl;

  assign cnt_prev  = CHAIN_AW'(cnt_r - 6'd1);
  assign cnt_ahead = cnt_r + 6'd2;
  assign chain_sel = fresh_r ? INIT_H[cnt_prev] : chain_rdata;
  assign len_byte  = bit_total_r[{~fill_r[2:0], 3'b000} +: 8];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    bit_total_nxt  = bit_total_r;
    fresh_nxt      = fresh_r;
    pad_nxt        = pad_r;
    sent80_nxt     = sent80_r;
    need_extra_nxt = need_extra_r;
    final_nxt      = final_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_idx_nxt    = out_idx_r;
    out_fin_nxt    = out_fin_r;
    word_nxt       = word_r;
    in_ready       = 1'b0;
    byte_en        = 1'b0;
    byte_val       = in_data_byte;
    blk_raddr      = cnt_ahead[BLK_AW-1:0];
    chain_raddr    = cnt_r[CHAIN_AW-1:0];
    chain_we       = 1'b0;
    chain_waddr    = cnt_prev;
    chain_wdata    = chain_sel + v_head;
    eng_ctrl       = '{v_shift: 1'b0, v_round: 1'b0, w_shift: 1'b0,
                       w_from_mem: 1'b0, rnd: cnt_r};

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pad_nxt    = in_end_of_message;
          sent80_nxt = 1'b0;
          if (in_has_byte) begin
            byte_en       = 1'b1;
            bit_total_nxt = bit_total_r + 64'd8;
          end
          if (in_has_byte && fill_r == FILL_LAST) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        byte_en = 1'b1;
        if (!sent80_r) begin
          byte_val       = PAD_BYTE;
          sent80_nxt     = 1'b1;
          need_extra_nxt = (fill_r[5:3] == 3'b111);
        end else if (fill_r[5:3] == 3'b111 && !need_extra_r) begin
          byte_val = len_byte;
        end else begin
          byte_val = 8'h00;
        end
        if (fill_r == FILL_LAST) begin
          final_nxt      = sent80_r && !need_extra_r;
          need_extra_nxt = 1'b0;
          state_nxt      = S_LOAD;
          cnt_nxt        = '0;
        end
      end
      S_LOAD: begin
        if (cnt_r != '0) begin
          eng_ctrl.v_shift = 1'b1;
        end
        if (cnt_r == SEQ_PREFETCH) begin
          blk_raddr = '0;
        end
        if (cnt_r == SEQ_LAST) begin
          blk_raddr           = BLK_AW'(1);
          eng_ctrl.w_shift    = 1'b1;
          eng_ctrl.w_from_mem = 1'b1;
          state_nxt           = S_ROUND;
          cnt_nxt             = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_ROUND: begin
        eng_ctrl.v_round    = 1'b1;
        eng_ctrl.w_shift    = 1'b1;
        eng_ctrl.w_from_mem = (cnt_r < ROUND_MEM_END);
        if (cnt_r == ROUND_LAST) begin
          state_nxt = S_UPDATE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_UPDATE: begin
        if (cnt_r != '0) begin
          chain_we         = 1'b1;
          eng_ctrl.v_shift = 1'b1;
        end
        if (cnt_r == SEQ_LAST) begin
          fresh_nxt = 1'b0;
          cnt_nxt   = '0;
          if (final_r) begin
            state_nxt = S_EMIT_RD;
          end else if (pad_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = chain_rdata;
        out_idx_nxt   = cnt_r[2:0];
        out_fin_nxt   = (cnt_r[2:0] == WORD_LAST);
        state_nxt     = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (cnt_r[2:0] == WORD_LAST) begin
            fresh_nxt     = 1'b1;
            bit_total_nxt = '0;
            pad_nxt       = 1'b0;
            sent80_nxt    = 1'b0;
            final_nxt     = 1'b0;
            cnt_nxt       = '0;
            state_nxt     = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 6'd1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    blk_we    = byte_en && (fill_r[1:0] == 2'b11);
    blk_waddr = fill_r[5:2];
    blk_wdata = {word_r, byte_val};
    if (byte_en) begin
      word_nxt = {word_r[15:0], byte_val};
      fill_nxt = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      fill_r       <= '0;
      bit_total_r  <= '0;
      fresh_r      <= 1'b1;
      pad_r        <= 1'b0;
      sent80_r     <= 1'b0;
      need_extra_r <= 1'b0;
      final_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_r       <= fill_nxt;
      bit_total_r  <= bit_total_nxt;
      fresh_r      <= fresh_nxt;
      pad_r        <= pad_nxt;
      sent80_r     <= sent80_nxt;
      need_extra_r <= need_extra_nxt;
      final_r      <= final_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  sha256sh_ram #(
    .WIDTH(32),
    .DEPTH(BLK_WORDS)
  ) u_blk_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(blk_waddr),
    .wdata(blk_wdata),
    .raddr(blk_raddr),
    .rdata(blk_rdata)
  );

  sha256sh_ram #(
    .WIDTH(32),
    .DEPTH(CHAIN_WORDS)
  ) u_chain_ram (
    .clk  (clk),
    .we   (chain_we),
    .waddr(chain_waddr),
    .wdata(chain_wdata),
    .raddr(chain_raddr),
    .rdata(chain_rdata)
  );

  sha256sh_engine u_engine (
    .clk     (clk),
    .ctrl    (eng_ctrl),
    .shift_in(chain_sel),
    .mem_word(blk_rdata),
    .v_head  (v_head)
  );

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_final_word  = out_fin_r;

  `SHS_ASSERT_NOW(a_no_input_during_digest, in_ready, !out_valid, "input open during digest")
  `SHS_ASSERT_NOW(a_block_ram_quiet, state_r == S_ROUND, !blk_we, "block write during rounds")
  `SHS_ASSERT_NEXT(a_rounds_to_update, state_r == S_ROUND && cnt_r == ROUND_LAST, state_r == S_UPDATE, "rounds overran")
  `SHS_ASSERT_NEXT(a_reinit_after_digest, out_valid && out_ready && out_final_word, fresh_r && fill_r == '0 && bit_total_r == '0 && state_r == S_IDLE, "no reinit after digest")

endmodule

// ===== rtl/sha256sh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the message block and the chaining words.
module sha256sh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sha256sh_engine.sv =====
// SHA-256 round engine: working variables, schedule window and round logic.
// Depends on sha256sh_pkg for the round constants and control struct.
module sha256sh_engine import sha256sh_pkg::*; (
  input  logic        clk,
  input  eng_ctrl_t   ctrl,
  input  logic [31:0] shift_in,
  input  logic [31:0] mem_word,
  output logic [31:0] v_head
);

  logic [31:0] v_r   [8];
  logic [31:0] v_nxt [8];
  logic [31:0] win_r   [16];
  logic [31:0] win_nxt [16];
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
    return (x >> s) | (x << (6'd32 - {1'b0, s}));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
  endfunction

  always_comb begin
    w_new = ctrl.w_from_mem ? mem_word
                            : win_r[0] + ssig0(win_r[1]) + win_r[9] + ssig1(win_r[14]);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + bsig1(v_r[4]) + ch + ROUND_K[ctrl.rnd] + win_r[15];
    t2  = bsig0(v_r[0]) + maj;

    v_nxt = v_r;
    if (ctrl.v_shift) begin
      for (int i = 0; i < 7; i++) begin
        v_nxt[i] = v_r[i+1];
      end
      v_nxt[7] = shift_in;
    end else if (ctrl.v_round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end

    win_nxt = win_r;
    if (ctrl.w_shift) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    win_r <= win_nxt;
  end

  assign v_head = v_r[0];

endmodule
